@@ sv/ile_pkg.sv @@
// Shared types, codes and tree sizing functions for the indexed list engine.
package ile_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int ACT_W        = 3;
  localparam int STAT_W       = 2;
  localparam int TREE_RADIX   = 16;

  localparam logic [ACT_W-1:0] ACT_READ       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_FRONT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INS_POS    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } cell_op_e;

  function automatic int tree_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = TREE_RADIX;
    while (span < n) begin
      span = span * TREE_RADIX;
      lv   = lv + 1;
    end
    return lv;
  endfunction

  function automatic int level_size(input int n, input int lv);
    int s;
    s = n;
    for (int k = 0; k < lv; k++) begin
      s = (s + TREE_RADIX - 1) / TREE_RADIX;
    end
    return s;
  endfunction

  function automatic int level_offset(input int n, input int lv);
    int off;
    off = 0;
    for (int k = 1; k < lv; k++) begin
      off = off + level_size(n, k);
    end
    return off;
  endfunction

  function automatic int tree_nodes(input int n);
    return level_offset(n, tree_levels(n) + 1);
  endfunction

endpackage

@@ sv/ile_cell.sv @@
// One list cell: holds one entry and shifts with its neighbors on insert and delete.
module ile_cell import ile_pkg::*; #(
  parameter int IDX_W = 10,
  parameter int INDEX = 0
) (
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic [IDX_W-1:0]  pos_i,
  input  logic [DATA_W-1:0] ins_value_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] value_o,
  output logic [DATA_W-1:0] tap_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] value_d;

  always_comb begin
    value_d = value_q;
    unique case (op_i)
      OP_INSERT: begin
        if (MyIdx > pos_i) begin
          value_d = left_i;
        end else if (MyIdx == pos_i) begin
          value_d = ins_value_i;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= pos_i) begin
          value_d = right_i;
        end
      end
      OP_READ: value_d = value_q;
      OP_NONE: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = (op_i == OP_READ && MyIdx == pos_i) ? value_q : '0;

endmodule

@@ sv/ile_or_tree.sv @@
// Registered sixteen-way OR reduction tree that gathers the selected cell onto one word.
module ile_or_tree import ile_pkg::*; #(
  parameter int N = CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic [DATA_W-1:0] leaf_i [N],
  output logic [DATA_W-1:0] root_o
);

  localparam int Levels = tree_levels(N);
  localparam int Nodes  = tree_nodes(N);

  logic [DATA_W-1:0] node_q [Nodes];
  logic [DATA_W-1:0] node_d [Nodes];

  always_comb begin
    logic [DATA_W-1:0] acc;
    int idx;
    for (int lv = 1; lv <= Levels; lv++) begin
      for (int j = 0; j < level_size(N, lv); j++) begin
        acc = '0;
        for (int k = 0; k < TREE_RADIX; k++) begin
          idx = j * TREE_RADIX + k;
          if (idx < level_size(N, lv - 1)) begin
            if (lv == 1) begin
              acc = acc | leaf_i[idx];
            end else begin
              acc = acc | node_q[level_offset(N, lv - 1) + idx];
            end
          end
        end
        node_d[level_offset(N, lv) + j] = acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
  end

  assign root_o = node_q[level_offset(N, Levels)];

endmodule

@@ sv/indexed_list_engine.sv @@
// Top level of the indexed list engine: command decode, length count, cell row and read tree.
// Each transaction starts when start_i is high while busy_o is low and always ends in exactly
// one result, shown on read_value_o and status_o while done_o is high for a single cycle; the
// receiver cannot stall, so it must take the result in that cycle. Inserts, appends, deletes,
// reads out of range and unknown actions strobe their result from the done register once the
// execute state has passed, since the whole cell row shifts at once in that state; busy_o stays
// high until then, so no new transaction is taken before the result. A read in range also waits
// in the drain state for the depth of the registered sixteen-way OR tree that collects the addressed cell.
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam int IdxW   = $clog2(CAPACITY);
  localparam int LenW   = $clog2(CAPACITY + 1);
  localparam int CmpW   = (LenW > POS_W - 1) ? LenW : POS_W - 1;
  localparam int Levels = tree_levels(CAPACITY);
  localparam int CntW   = $clog2(Levels + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StExec  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   length_q, length_d;
  cell_op_e          op_q, op_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [DATA_W-1:0] ins_q, ins_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [DATA_W-1:0] rd_q, rd_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] rv_q, rv_d;
  logic [STAT_W-1:0] st_q, st_d;

  logic              neg;
  logic              full;
  logic [CmpW-1:0]   pos_c;
  logic [CmpW-1:0]   len_c;
  cell_op_e          cell_op;
  logic [DATA_W-1:0] root;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_tap [CAPACITY];

  assign neg   = position_i[POS_W-1];
  assign pos_c = CmpW'(position_i[POS_W-2:0]);
  assign len_c = CmpW'(length_q);
  assign full  = (length_q == LenW'(CAPACITY));

  always_comb begin
    op_d     = OP_NONE;
    pos_d    = '0;
    ins_d    = value_i;
    stat_d   = STAT_DONE;
    rd_d     = '0;
    length_d = length_q;
    unique case (action_i)
      ACT_READ: begin
        if (neg || pos_c >= len_c) begin
          stat_d = STAT_RANGE;
          rd_d   = '1;
        end else begin
          op_d  = OP_READ;
          pos_d = IdxW'(pos_c);
        end
      end
      ACT_INS_FRONT: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          op_d     = OP_INSERT;
          length_d = length_q + 1'b1;
        end
      end
      ACT_APPEND: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          op_d     = OP_INSERT;
          pos_d    = IdxW'(length_q);
          length_d = length_q + 1'b1;
        end
      end
      ACT_INS_POS: begin
        if (neg || pos_c == '0) begin
          if (full) begin
            stat_d = STAT_FULL;
          end else begin
            op_d     = OP_INSERT;
            length_d = length_q + 1'b1;
          end
        end else if (pos_c > len_c) begin
          stat_d = STAT_RANGE;
        end else if (full) begin
          stat_d = STAT_FULL;
        end else begin
          op_d     = OP_INSERT;
          pos_d    = IdxW'(pos_c);
          length_d = length_q + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (neg || pos_c >= len_c) begin
          stat_d = STAT_RANGE;
        end else begin
          op_d     = OP_DELETE;
          pos_d    = IdxW'(pos_c);
          length_d = length_q - 1'b1;
        end
      end
      default: begin
        stat_d = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rv_d    = rv_q;
    st_d    = st_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (op_q == OP_READ) begin
          state_d = StDrain;
          cnt_d   = CntW'(Levels - 1);
        end else begin
          state_d = StIdle;
          done_d  = 1'b1;
          rv_d    = rd_q;
          st_d    = stat_q;
        end
      end
      StDrain: begin
        if (cnt_q == '0) begin
          state_d = StIdle;
          done_d  = 1'b1;
          rv_d    = root;
          st_d    = STAT_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      length_q <= '0;
      op_q     <= OP_NONE;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (state_q == StIdle && start_i) begin
        length_q <= length_d;
        op_q     <= op_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      pos_q  <= pos_d;
      ins_q  <= ins_d;
      stat_q <= stat_d;
      rd_q   <= rd_d;
    end
    rv_q <= rv_d;
    st_q <= st_d;
  end

  assign cell_op = (state_q == StExec) ? op_q : OP_NONE;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = ins_q;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_val[i];
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end
    ile_cell #(
      .IDX_W (IdxW),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .pos_i       (pos_q),
      .ins_value_i (ins_q),
      .left_i      (left),
      .right_i     (right),
      .value_o     (cell_val[i]),
      .tap_o       (cell_tap[i])
    );
  end

  ile_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_tap),
    .root_o (root)
  );

  assign busy_o       = (state_q != StIdle);
  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

endmodule
